FILE: hdl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/rau_pkg.sv
// Package for the rational arithmetic unit: codes, widths and types.
package rau_pkg;
    localparam int OPERAND_BITS_DEF = 32;
    localparam int MAG_W = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic       start;
        logic       is_div;
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] y;
    } t_alu_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M1,
        S_M2,
        S_M3,
        S_SUM,
        S_GCD,
        S_GCDW,
        S_DN,
        S_DNW,
        S_DD,
        S_DDW,
        S_OUT
    } t_state;
endpackage

FILE: hdl/rau_alu.sv
// Shared shift-add unit: 64-bit product of two 32-bit values, or 64-bit divide.
module rau_alu (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rau_pkg::t_alu_req                     i_req,
    output logic                                  o_done,
    output logic [rau_pkg::MAG_W-1:0]             o_q,
    output logic [rau_pkg::MAG_W-1:0]             o_r
);
    import rau_pkg::*;

    logic [MAG_W-1:0] r_a, n_a;
    logic [MAG_W-1:0] r_b, n_b;
    logic [MAG_W-1:0] r_acc, n_acc;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_div, n_div;
    logic             r_done, n_done;
    logic [MAG_W:0]   trial;
    logic [MAG_W-1:0] rem_sh;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;
        rem_sh = {r_acc[MAG_W-2:0], r_a[MAG_W-1]};
        trial  = {1'b0, rem_sh} - {1'b0, r_b};
        if (i_req.start) begin
            n_a    = i_req.x;
            n_b    = i_req.y;
            n_acc  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
            n_div  = i_req.is_div;
        end else if (r_busy) begin
            if (r_div) begin
                // restoring division, one quotient bit a cycle; quotient in r_a
                if (!trial[MAG_W] || r_acc[MAG_W-1]) begin
                    n_acc = trial[MAG_W-1:0];
                    n_a   = {r_a[MAG_W-2:0], 1'b1};
                end else begin
                    n_acc = rem_sh;
                    n_a   = {r_a[MAG_W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[MAG_W-2:0], 1'b0};
                n_b = {1'b0, r_b[MAG_W-1:1]};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(r_div ? MAG_W - 1 : MAG_W / 2 - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_q    = r_div ? r_a : r_acc;
    assign o_r    = r_acc;
endmodule

FILE: hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer around one shared shift-add unit.
//
//  channel  | ports                                    | handshake
//  request  | i_command i_a_num i_a_den i_b_num i_b_den | i_start while o_busy low
//  result   | o_res_num o_res_den o_status              | o_done strobe, one cycle
//
// The sequence is three products, one divide per Euclid step, then two exact
// divides, all on the shared shift-add unit. Errors go straight from the operand
// check to the result state.
// Reset is synchronous and clears the sequencer; the receiver cannot stall.
module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [1:0]              i_command,
    input  logic signed [31:0]      i_a_num,
    input  logic [30:0]             i_a_den,
    input  logic signed [31:0]      i_b_num,
    input  logic [30:0]             i_b_den,
    output logic                    o_done,
    output logic signed [31:0]      o_res_num,
    output logic [30:0]             o_res_den,
    output logic [1:0]              o_status
);
    import rau_pkg::*;
    `include "rational_arithmetic_unit_assert.svh"

    localparam int OB = OPERAND_BITS;
    localparam logic [31:0] NMASK = 32'((64'd1 << OB) - 64'd1);
    localparam logic [31:0] DMASK = 32'((64'd1 << (OB - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] LIM_POS = MAG_W'(DMASK);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [31:0]      r_an, n_an, r_bn, n_bn, r_ad, n_ad, r_bd, n_bd;
    logic             r_ang, n_ang, r_bng, n_bng;
    logic [MAG_W-1:0] r_t1, n_t1, r_t2, n_t2, r_den, n_den;
    logic [MAG_W-1:0] r_x, n_x, r_y, n_y, r_num, n_num;
    logic             r_neg, n_neg;
    logic             r_done, n_done;
    logic [31:0]      r_rnum, n_rnum;
    logic [30:0]      r_rden, n_rden;
    t_status          r_stat, n_stat;
    t_alu_req         alu_req;
    logic             alu_done;
    logic [MAG_W-1:0] alu_q, alu_r;
    logic [31:0]      va, vb, ma, mb;
    logic             t2neg;
    logic [MAG_W-1:0] nmag, nlim;

    rau_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_done (alu_done),
        .o_q    (alu_q),
        .o_r    (alu_r)
    );

    always_comb begin
        va = 32'(i_a_num) & NMASK;
        vb = 32'(i_b_num) & NMASK;
        ma = va[OB-1] ? ((~va + 32'd1) & NMASK) : va;
        mb = vb[OB-1] ? ((~vb + 32'd1) & NMASK) : vb;
        t2neg = (r_cmd == CMD_SUB) ? !r_bng : r_bng;
        nmag  = r_num;
        nlim  = r_neg ? LIM_POS + MAG_W'(1) : LIM_POS;
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd; n_an = r_an; n_bn = r_bn; n_ad = r_ad; n_bd = r_bd;
        n_ang = r_ang; n_bng = r_bng;
        n_t1 = r_t1; n_t2 = r_t2; n_den = r_den;
        n_x = r_x; n_y = r_y; n_num = r_num; n_neg = r_neg;
        n_done = 1'b0;
        n_rnum = r_rnum; n_rden = r_rden; n_stat = r_stat;
        alu_req = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = t_cmd'(i_command);
                    n_an  = ma;
                    n_bn  = mb;
                    n_ang = va[OB-1];
                    n_bng = vb[OB-1];
                    n_ad  = 32'(i_a_den) & DMASK;
                    n_bd  = 32'(i_b_den) & DMASK;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                if (r_ad == '0 || r_bd == '0
                    || (r_cmd == CMD_DIV && r_bn == '0)) begin
                    n_rnum = '0; n_rden = 31'd1; n_stat = ST_ERR;
                    n_state = S_OUT;
                end else begin
                    alu_req.start = 1'b1;
                    alu_req.x = MAG_W'(r_an);
                    alu_req.y = (r_cmd == CMD_MUL) ? MAG_W'(r_bn) : MAG_W'(r_bd);
                    n_state = S_M2;
                end
            end
            S_M2: begin
                if (alu_done) begin
                    n_t1 = alu_q;
                    alu_req.start = 1'b1;
                    alu_req.x = MAG_W'(r_ad);
                    alu_req.y = (r_cmd == CMD_DIV) ? MAG_W'(r_bn) : MAG_W'(r_bd);
                    n_state = S_M3;
                end
            end
            S_M3: begin
                if (alu_done) begin
                    n_den = alu_q;
                    alu_req.start = 1'b1;
                    alu_req.x = MAG_W'(r_bn);
                    alu_req.y = MAG_W'(r_ad);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (alu_done) begin
                    n_t2 = alu_q;
                    if (r_cmd == CMD_MUL || r_cmd == CMD_DIV) begin
                        n_num = r_t1;
                        n_neg = r_ang != r_bng;
                    end else if (r_ang == t2neg) begin
                        n_num = r_t1 + alu_q;
                        n_neg = r_ang;
                    end else if (r_t1 >= alu_q) begin
                        n_num = r_t1 - alu_q;
                        n_neg = r_ang;
                    end else begin
                        n_num = alu_q - r_t1;
                        n_neg = t2neg;
                    end
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_num == '0) r_neg_clear: n_neg = 1'b0;
                n_x = r_num;
                n_y = r_den;
                n_state = S_GCDW;
                if (r_den != '0) begin
                    alu_req.start = 1'b1; alu_req.is_div = 1'b1;
                    alu_req.x = r_num; alu_req.y = r_den;
                end
            end
            S_GCDW: begin
                if (r_y == '0) begin
                    alu_req.start = 1'b1; alu_req.is_div = 1'b1;
                    alu_req.x = r_num; alu_req.y = r_x;
                    n_state = S_DNW;
                end else if (alu_done) begin
                    n_x = r_y;
                    n_y = alu_r;
                    if (alu_r != '0) begin
                        alu_req.start = 1'b1; alu_req.is_div = 1'b1;
                        alu_req.x = r_y; alu_req.y = alu_r;
                    end
                end
            end
            S_DNW: begin
                if (alu_done) begin
                    n_num = alu_q;
                    alu_req.start = 1'b1; alu_req.is_div = 1'b1;
                    alu_req.x = r_den; alu_req.y = r_x;
                    n_state = S_DDW;
                end
            end
            S_DDW: begin
                if (alu_done) begin
                    if (alu_q > LIM_POS || nmag > nlim) begin
                        n_rnum = '0; n_rden = 31'd1; n_stat = ST_OVF;
                    end else begin
                        n_rnum = r_neg ? 32'(~nmag + MAG_W'(1)) : 32'(nmag);
                        n_rden = 31'(alu_q);
                        n_stat = ST_OK;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cmd <= n_cmd; r_an <= n_an; r_bn <= n_bn; r_ad <= n_ad; r_bd <= n_bd;
        r_ang <= n_ang; r_bng <= n_bng;
        r_t1 <= n_t1; r_t2 <= n_t2; r_den <= n_den;
        r_x <= n_x; r_y <= n_y; r_num <= n_num; r_neg <= n_neg;
        r_rnum <= n_rnum; r_rden <= n_rden; r_stat <= n_stat;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_res_num = r_rnum;
    assign o_res_den = r_rden;
    assign o_status  = r_stat;

    `RAU_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, o_done, o_res_den != 31'd0)
    `RAU_ASSERT_IMP(a_no_rsvd, i_clk, i_rst_n, o_done, o_status != ST_RSVD)
    `RAU_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !o_done)
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_done && o_status != ST_OK,
        o_res_num == 32'd0 && o_res_den == 31'd1)
endmodule

FILE: bench/tb.sv
// Testbench for the rational arithmetic unit: random and directed requests against a predictor.
module tb;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        t_status            status;
    } t_fraction;

    class fraction_scoreboard;
        t_fraction pending[$];
        int        mismatches;

        function t_fraction reduce(t_cmd cmd, logic signed [31:0] an, logic [30:0] ad,
                                   logic signed [31:0] bn, logic [30:0] bd);
            t_fraction r;
            logic [63:0] amag, bmag, t1, t2, nmag, den, x, y, tmp;
            logic        aneg, bneg, t2neg, nneg;
            r.num = 0;
            r.den = 1;
            r.status = ST_ERR;
            aneg = an[31];
            bneg = bn[31];
            amag = aneg ? 64'(-{32'b0, an}) & 64'hFFFF_FFFF : 64'({32'b0, an});
            bmag = bneg ? 64'(-{32'b0, bn}) & 64'hFFFF_FFFF : 64'({32'b0, bn});
            if (ad == 0 || bd == 0) return r;
            if (cmd == CMD_DIV && bmag == 0) return r;
            case (cmd)
                CMD_ADD, CMD_SUB: begin
                    t1 = amag * bd;
                    t2 = bmag * ad;
                    t2neg = (cmd == CMD_SUB) ? !bneg : bneg;
                    if (aneg == t2neg) begin
                        nneg = aneg;
                        nmag = t1 + t2;
                    end else if (t1 >= t2) begin
                        nneg = aneg;
                        nmag = t1 - t2;
                    end else begin
                        nneg = t2neg;
                        nmag = t2 - t1;
                    end
                    den = 64'(ad) * bd;
                end
                CMD_MUL: begin
                    nmag = amag * bmag;
                    nneg = aneg != bneg;
                    den = 64'(ad) * bd;
                end
                default: begin
                    nmag = amag * bd;
                    nneg = aneg != bneg;
                    den = 64'(ad) * bmag;
                end
            endcase
            if (nmag == 0) nneg = 0;
            x = nmag;
            y = den;
            while (y != 0) begin
                tmp = x % y;
                x = y;
                y = tmp;
            end
            nmag = nmag / x;
            den = den / x;
            if (den > 64'h7FFF_FFFF || nmag > (nneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
                r.status = ST_OVF;
                return r;
            end
            r.num = nneg ? -nmag[31:0] : nmag[31:0];
            r.den = den[30:0];
            r.status = ST_OK;
            return r;
        endfunction

        function void note_request(t_cmd cmd, logic signed [31:0] an, logic [30:0] ad,
                                   logic signed [31:0] bn, logic [30:0] bd);
            pending.push_back(reduce(cmd, an, ad, bn, bd));
        endfunction

        function void check_result(logic signed [31:0] num, logic [30:0] den, logic [1:0] st);
            t_fraction e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d/%0d st %0d", num, den, st);
                return;
            end
            e = pending.pop_front();
            if (num !== e.num || den !== e.den || st !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                             e.num, e.den, e.status, num, den, st);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, i_start;
    logic               o_busy, o_done;
    logic [1:0]         i_command;
    logic signed [31:0] i_a_num, i_b_num;
    logic [30:0]        i_a_den, i_b_den;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic [1:0]         o_status;

    fraction_scoreboard board;
    int                 stalled;
    bit                 calm;

    rational_arithmetic_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_res_num, o_res_den, o_status);
        if (i_rst_n && ((i_start && !o_busy) || o_done)) stalled = 0;
        else stalled++;
        if (stalled > 200000) begin
            $display("[rational_arithmetic_unit] ERROR");
            $finish;
        end
    end

    // the unit stays busy after taking a request, so start may stay
    // high until the next request is set up; it drops only for idle bursts
    task automatic send(t_cmd cmd, logic signed [31:0] an, logic [30:0] ad,
                        logic signed [31:0] bn, logic [30:0] bd);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1;
        i_command <= cmd;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (o_busy);
        board.note_request(cmd, an, ad, bn, bd);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: rand_word = $urandom_range(0, 20);
            1: rand_word = -$urandom_range(0, 20);
            2: rand_word = $urandom_range(0, 4000) - 2000;
            3: rand_word = 32'h8000_0000 + $urandom_range(0, 3);
            default: rand_word = $urandom;
        endcase
    endfunction

    initial begin
        t_cmd cmd;
        logic [31:0] w;
        logic [30:0] d1, d2;
        board = new();
        stalled = 0;
        calm = 0;
        i_rst_n = 0;
        i_start = 0;
        i_command = CMD_ADD;
        i_a_num = 0;
        i_a_den = 1;
        i_b_num = 0;
        i_b_den = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(CMD_ADD, 1, 2, 1, 3);
        send(CMD_SUB, 1, 2, 1, 2);
        send(CMD_MUL, -3, 4, 2, 9);
        send(CMD_DIV, 3, 4, -9, 2);
        send(CMD_ADD, 1, 0, 1, 1);
        send(CMD_MUL, 1, 1, 1, 0);
        send(CMD_DIV, 5, 7, 0, 3);
        send(CMD_MUL, 0, 5, 7, 9);
        send(CMD_ADD, 32'h7FFF_FFFF, 1, 1, 1);
        send(CMD_SUB, 32'h8000_0000, 1, 1, 1);
        send(CMD_SUB, 32'h8000_0000, 1, 0, 1);
        send(CMD_MUL, 32'h8000_0000, 1, -1, 1);
        send(CMD_DIV, 32'h8000_0000, 31'h7FFF_FFFF, -1, 31'h7FFF_FFFF);
        send(CMD_MUL, 1, 31'h7FFF_FFFF, 1, 2);
        send(CMD_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(CMD_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE);
        i_start <= 0;

        // hold off until the unit has drained
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);

        for (int k = 0; k < 750; k++) begin
            if (k == 650) calm = 1;
            cmd = t_cmd'($urandom_range(0, 3));
            d1 = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(1, 60));
            d2 = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(1, 60));
            if ($urandom_range(0, 40) == 0) d1 = 0;
            if ($urandom_range(0, 40) == 0) d2 = 0;
            w = rand_word();
            if ($urandom_range(0, 30) == 0) w = 0;
            send(cmd, rand_word(), d1, w, d2);
        end
        i_start <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end
endmodule
